// File: sv/ght_pkg.sv
// shared constants, codes and types of the generational handle table
package ght_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int GEN_BITS   = 16;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam int ACTION_W   = 3;
    localparam int OWNER_W    = 16;
    localparam int HIDX_W     = 8;
    localparam int HGEN_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int LIVE_W     = 9;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic REG_OWNER_IDX = 1'b0;
    localparam logic [OWNER_W-1:0] OWNER_RESET = OWNER_W'(1);

    localparam logic [GEN_BITS-1:0] GEN_MAX   = '1;
    localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_LOOKUP = 3'd3,
        ACT_STALE  = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_STALE    = 2'd1,
        ST_BAD_DESC = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_EXEC,
        S_CLR_RD,
        S_CLR_WR,
        S_DONE
    } t_state;

    // one slot memory word
    typedef struct packed {
        logic                retired;
        logic                occupied;
        logic [GEN_BITS-1:0] gen;
    } t_slot;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                handle_present;
        logic [OWNER_W-1:0]  handle_owner;
        logic [HIDX_W-1:0]   handle_index;
        logic [HGEN_W-1:0]   handle_generation;
        logic                descriptor_ok;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [HIDX_W-1:0]   out_index;
        logic [HGEN_W-1:0]   out_generation;
        logic                is_stale;
        logic [LIVE_W-1:0]   live_count;
    } t_rsp;

    // bookkeeping counters seen by the top level
    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] live;
        logic [CNT_W-1:0] slots_used;
        logic [CNT_W-1:0] free_depth;
    } t_stat;

endpackage

// File: sv/ght_if.sv
// request and result channel interfaces
interface ght_req_if;
    import ght_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                handle_present;
    logic [OWNER_W-1:0]  handle_owner;
    logic [HIDX_W-1:0]   handle_index;
    logic [HGEN_W-1:0]   handle_generation;
    logic                descriptor_ok;

    modport source (
        output valid, action, handle_present, handle_owner, handle_index,
               handle_generation, descriptor_ok,
        input  ready
    );
    modport sink (
        input  valid, action, handle_present, handle_owner, handle_index,
               handle_generation, descriptor_ok,
        output ready
    );
endinterface

interface ght_rsp_if;
    import ght_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HIDX_W-1:0]   out_index;
    logic [HGEN_W-1:0]   out_generation;
    logic                is_stale;
    logic [LIVE_W-1:0]   live_count;

    modport source (
        output valid, status, out_index, out_generation, is_stale, live_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_index, out_generation, is_stale, live_count,
        output ready
    );
endinterface

// File: sv/ght_ram.sv
// single-port-write, registered-read memory
module ght_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: sv/ght_ctrl.sv
// request sequencer: reads slot and free stack memories, decides, writes back
module ght_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ght_pkg::OWNER_W-1:0]   i_owner_id,
    ght_req_if.sink                       i_req,
    ght_rsp_if.source                     o_rsp,
    output logic                          o_slot_rd_en,
    output logic [ght_pkg::IDX_W-1:0]     o_slot_rd_addr,
    input  ght_pkg::t_slot                i_slot_rd_data,
    output logic                          o_slot_we,
    output logic [ght_pkg::IDX_W-1:0]     o_slot_wr_addr,
    output ght_pkg::t_slot                o_slot_wr_data,
    output logic                          o_stk_rd_en,
    output logic [ght_pkg::IDX_W-1:0]     o_stk_rd_addr,
    input  logic [ght_pkg::IDX_W-1:0]     i_stk_rd_data,
    output logic                          o_stk_we,
    output logic [ght_pkg::IDX_W-1:0]     o_stk_wr_addr,
    output logic [ght_pkg::IDX_W-1:0]     o_stk_wr_data,
    output ght_pkg::t_stat                o_stat
);
    import ght_pkg::*;

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic             r_popped, n_popped;
    logic [IDX_W-1:0] r_pop_idx, n_pop_idx;
    logic [CNT_W-1:0] r_free_depth, n_free_depth;
    logic [CNT_W-1:0] r_slots_used, n_slots_used;
    logic [CNT_W-1:0] r_live, n_live;
    logic [CNT_W-1:0] r_clr_idx, n_clr_idx;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             accept;
    logic             can_emit;
    logic             hit;
    logic             push_req;
    logic [IDX_W-1:0] push_idx;
    logic [CNT_W-1:0] stack_top;
    logic [IDX_W-1:0] req_idx;
    t_rsp             rsp;

    // advance generation, or retire the slot when it would wrap
    function automatic t_slot release_word(input t_slot w);
        t_slot r;
        r          = w;
        r.occupied = 1'b0;
        if (w.gen == GEN_MAX) begin
            r.retired = 1'b1;
        end else begin
            r.gen = GEN_BITS'(w.gen + 1'b1);
        end
        return r;
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign can_emit    = !r_out_valid || o_rsp.ready;
    assign stack_top   = CNT_W'(r_free_depth - 1'b1);
    assign req_idx     = r_req.handle_index[IDX_W-1:0];

    assign hit = r_req.handle_present
              && (r_req.handle_owner == i_owner_id)
              && (CNT_W'(r_req.handle_index) < r_slots_used)
              && !i_slot_rd_data.retired
              && i_slot_rd_data.occupied
              && (i_slot_rd_data.gen == GEN_BITS'(r_req.handle_generation));

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_popped     = r_popped;
        n_pop_idx    = r_pop_idx;
        n_free_depth = r_free_depth;
        n_slots_used = r_slots_used;
        n_live       = r_live;
        n_clr_idx    = r_clr_idx;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        o_slot_rd_en   = 1'b0;
        o_slot_rd_addr = i_req.handle_index[IDX_W-1:0];
        o_slot_we      = 1'b0;
        o_slot_wr_addr = req_idx;
        o_slot_wr_data = i_slot_rd_data;
        o_stk_rd_en    = 1'b0;
        o_stk_rd_addr  = stack_top[IDX_W-1:0];
        push_req       = 1'b0;
        push_idx       = req_idx;

        rsp = '{status: ST_OK, out_index: '0, out_generation: '0,
                is_stale: 1'b0, live_count: '0};

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_slot_rd_en = accept;
                o_stk_rd_en  = accept;
                if (accept) begin
                    n_req.action            = i_req.action;
                    n_req.handle_present    = i_req.handle_present;
                    n_req.handle_owner      = i_req.handle_owner;
                    n_req.handle_index      = i_req.handle_index;
                    n_req.handle_generation = i_req.handle_generation;
                    n_req.descriptor_ok     = i_req.descriptor_ok;
                    n_popped                = 1'b0;
                    if (i_req.action == ACT_ADD && i_req.descriptor_ok
                            && r_free_depth != '0) begin
                        n_state = S_POP;
                    end else if (i_req.action == ACT_CLEAR) begin
                        n_free_depth = '0;
                        n_live       = '0;
                        n_clr_idx    = '0;
                        n_state      = S_CLR_RD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_POP: begin
                // slot index from the stack top, then fetch its word
                o_slot_rd_en   = 1'b1;
                o_slot_rd_addr = i_stk_rd_data;
                n_pop_idx      = i_stk_rd_data;
                n_popped       = 1'b1;
                n_free_depth   = stack_top;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                if (can_emit) begin
                    unique case (r_req.action)
                        ACT_ADD: begin
                            if (!r_req.descriptor_ok) begin
                                rsp.status = ST_BAD_DESC;
                            end else if (r_popped) begin
                                o_slot_we               = 1'b1;
                                o_slot_wr_addr          = r_pop_idx;
                                o_slot_wr_data.occupied = 1'b1;
                                n_live                  = CNT_W'(r_live + 1'b1);
                                rsp.out_index           = HIDX_W'(r_pop_idx);
                                rsp.out_generation      = HGEN_W'(i_slot_rd_data.gen);
                            end else if (r_slots_used == CNT_W'(SLOT_COUNT)) begin
                                rsp.status = ST_FULL;
                            end else begin
                                o_slot_we          = 1'b1;
                                o_slot_wr_addr     = r_slots_used[IDX_W-1:0];
                                o_slot_wr_data     = '{retired: 1'b0, occupied: 1'b1,
                                                       gen: GEN_FIRST};
                                n_slots_used       = CNT_W'(r_slots_used + 1'b1);
                                n_live             = CNT_W'(r_live + 1'b1);
                                rsp.out_index      = HIDX_W'(r_slots_used[IDX_W-1:0]);
                                rsp.out_generation = HGEN_W'(GEN_FIRST);
                            end
                        end
                        ACT_UPDATE: begin
                            if (!hit) begin
                                rsp.status = ST_STALE;
                            end else begin
                                rsp.out_index = r_req.handle_index;
                                if (!r_req.descriptor_ok) begin
                                    rsp.status = ST_BAD_DESC;
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (!hit) begin
                                rsp.status = ST_STALE;
                            end else begin
                                o_slot_we      = 1'b1;
                                o_slot_wr_data = release_word(i_slot_rd_data);
                                push_req       = (i_slot_rd_data.gen != GEN_MAX);
                                if (r_live != '0) begin
                                    n_live = CNT_W'(r_live - 1'b1);
                                end
                                rsp.out_index = r_req.handle_index;
                            end
                        end
                        ACT_LOOKUP: begin
                            if (hit) begin
                                rsp.out_index = r_req.handle_index;
                            end else begin
                                rsp.status = ST_STALE;
                            end
                        end
                        ACT_STALE: begin
                            if (hit) begin
                                rsp.out_index = r_req.handle_index;
                            end
                            rsp.is_stale = r_req.handle_present && !hit;
                        end
                        default: begin
                        end
                    endcase
                    rsp.live_count = LIVE_W'(n_live);
                    n_out          = rsp;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLR_RD: begin
                o_slot_rd_en   = 1'b1;
                o_slot_rd_addr = r_clr_idx[IDX_W-1:0];
                if (r_clr_idx == r_slots_used) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CLR_WR;
                end
            end
            S_CLR_WR: begin
                o_slot_we      = 1'b1;
                o_slot_wr_addr = r_clr_idx[IDX_W-1:0];
                if (i_slot_rd_data.retired) begin
                    o_slot_wr_data.occupied = 1'b0;
                end else begin
                    o_slot_wr_data = release_word(i_slot_rd_data);
                    push_req       = (i_slot_rd_data.gen != GEN_MAX);
                end
                push_idx  = r_clr_idx[IDX_W-1:0];
                n_clr_idx = CNT_W'(r_clr_idx + 1'b1);
                n_state   = S_CLR_RD;
            end
            S_DONE: begin
                if (can_emit) begin
                    rsp.live_count = LIVE_W'(r_live);
                    n_out          = rsp;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // freed slot goes on top of the stack
    always_comb begin
        o_stk_we      = 1'b0;
        o_stk_wr_addr = r_free_depth[IDX_W-1:0];
        o_stk_wr_data = push_idx;
        if (push_req && r_free_depth < CNT_W'(SLOT_COUNT)) begin
            o_stk_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_popped     <= 1'b0;
            r_free_depth <= '0;
            r_slots_used <= '0;
            r_live       <= '0;
            r_clr_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_popped     <= n_popped;
            r_free_depth <= o_stk_we ? CNT_W'(n_free_depth + 1'b1) : n_free_depth;
            r_slots_used <= n_slots_used;
            r_live       <= n_live;
            r_clr_idx    <= n_clr_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_pop_idx <= n_pop_idx;
        r_out     <= n_out;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.out_index      = r_out.out_index;
    assign o_rsp.out_generation = r_out.out_generation;
    assign o_rsp.is_stale       = r_out.is_stale;
    assign o_rsp.live_count     = r_out.live_count;

    assign o_stat = '{idle: (r_state == S_IDLE), live: r_live,
                      slots_used: r_slots_used, free_depth: r_free_depth};
endmodule

// File: sv/generational_handle_table.sv
// top level: config register, slot and free stack memories, request sequencer
//
//  channel  dir  handshake        payload
//  i_req    in   valid/ready      action, handle_present/owner/index/generation, descriptor_ok
//  o_rsp    out  valid/ready      status, out_index, out_generation, is_stale, live_count
//  apb      in   psel/penable     owner_id at byte address 0 (paddr[2] selects register)
//
// one request at a time: after accept the execute state loads the result register; an add
// that reuses a freed slot passes the pop state first (stack read, then slot read), as both
// memory reads are registered; the sequencer then returns to idle for the next request
// clear walks the slot memory, one read and one write per slot, then loads its result from
// the done state; a finished result waits in the output register while the next request
// enters
// reset is synchronous, clears counters and control, loads owner_id; memories need no clearing
// a stalled result holds the sequencer in its final state until the output is taken
module generational_handle_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ght_req_if.sink                       i_req,
    ght_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ght_pkg::PADDR_W-1:0]   paddr,
    input  logic [ght_pkg::PDATA_W-1:0]   pwdata,
    output logic [ght_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import ght_pkg::*;

    logic [OWNER_W-1:0] r_owner_id;

    logic             slot_rd_en;
    logic [IDX_W-1:0] slot_rd_addr;
    t_slot            slot_rd_data;
    logic             slot_we;
    logic [IDX_W-1:0] slot_wr_addr;
    t_slot            slot_wr_data;
    logic             stk_rd_en;
    logic [IDX_W-1:0] stk_rd_addr;
    logic [IDX_W-1:0] stk_rd_data;
    logic             stk_we;
    logic [IDX_W-1:0] stk_wr_addr;
    logic [IDX_W-1:0] stk_wr_data;
    t_stat            stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_id <= OWNER_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_OWNER_IDX) begin
            r_owner_id <= pwdata[OWNER_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_OWNER_IDX) ? PDATA_W'(r_owner_id) : '0;

    ght_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH ($bits(t_slot))
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_data),
        .i_we      (slot_we),
        .i_wr_addr (slot_wr_addr),
        .i_wr_data (slot_wr_data)
    );

    ght_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_rd_en   (stk_rd_en),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data),
        .i_we      (stk_we),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (stk_wr_data)
    );

    ght_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_owner_id     (r_owner_id),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_slot_rd_en   (slot_rd_en),
        .o_slot_rd_addr (slot_rd_addr),
        .i_slot_rd_data (slot_rd_data),
        .o_slot_we      (slot_we),
        .o_slot_wr_addr (slot_wr_addr),
        .o_slot_wr_data (slot_wr_data),
        .o_stk_rd_en    (stk_rd_en),
        .o_stk_rd_addr  (stk_rd_addr),
        .i_stk_rd_data  (stk_rd_data),
        .o_stk_we       (stk_we),
        .o_stk_wr_addr  (stk_wr_addr),
        .o_stk_wr_data  (stk_wr_data),
        .o_stat         (stat)
    );

    // live and free slots are disjoint subsets of the appended slots
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.live <= stat.slots_used)
        else $error("live count exceeds appended slots");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, stat.free_depth} + {1'b0, stat.live}) <= {1'b0, stat.slots_used})
        else $error("free and live slots overlap");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while one is in flight");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.idle |-> !(slot_we || stk_we))
        else $error("memory written with no request in flight");
endmodule

// File: sim/tb_top.sv
// testbench for the generational handle table: directed, generation, capacity and random traffic
module tb_top;
    import ght_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;
    localparam logic [PADDR_W-1:0]  OWNER_ADDR = {REG_OWNER_IDX, 2'b00};

    localparam int IDLE_PCT         = 17;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 340;
    localparam int CLEAR_ROUNDS     = 40;
    localparam int TAIL_CYCLES      = 2 * SLOT_COUNT + 64;
    localparam int WATCHDOG_LIMIT   = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    ght_req_if req_if ();
    ght_rsp_if rsp_if ();

    generational_handle_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the table
    logic [GEN_BITS-1:0] m_gen      [SLOT_COUNT];
    bit                  m_occupied [SLOT_COUNT];
    bit                  m_retired  [SLOT_COUNT];
    logic [IDX_W-1:0]    m_free     [SLOT_COUNT];
    logic [CNT_W-1:0]    m_free_depth;
    logic [CNT_W-1:0]    m_slots_used;
    logic [CNT_W-1:0]    m_live;
    logic [OWNER_W-1:0]  m_owner;

    t_rsp awaited_replies [$];
    t_rsp last_reply;
    int   err_count;
    bit   no_idle;
    bit   rsp_hold_start;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit handle_live(t_req r);
        if (!r.handle_present) return 1'b0;
        if (r.handle_owner != m_owner) return 1'b0;
        if ({1'b0, r.handle_index} >= m_slots_used) return 1'b0;
        if (m_retired[r.handle_index] || !m_occupied[r.handle_index]) return 1'b0;
        return m_gen[r.handle_index] == r.handle_generation;
    endfunction

    // advance the generation; a slot at the top generation is retired instead
    function automatic void release_slot(logic [IDX_W-1:0] idx);
        if (m_gen[idx] == GEN_MAX) begin
            m_retired[idx] = 1'b1;
        end else begin
            m_gen[idx] = m_gen[idx] + 1'b1;
            if (m_free_depth < SLOT_COUNT) begin
                m_free[m_free_depth[IDX_W-1:0]] = idx;
                m_free_depth++;
            end
        end
    endfunction

    function automatic t_rsp apply_action(t_req r);
        t_rsp             o;
        bit               hit;
        logic [IDX_W-1:0] k;
        o = '0;
        o.status = ST_OK;
        hit = handle_live(r);
        case (r.action)
            ACT_ADD: begin
                if (!r.descriptor_ok) begin
                    o.status = ST_BAD_DESC;
                end else if (m_free_depth != 0) begin
                    m_free_depth--;
                    k = m_free[m_free_depth[IDX_W-1:0]];
                    m_occupied[k] = 1'b1;
                    m_live++;
                    o.out_index = k;
                    o.out_generation = m_gen[k];
                end else if (m_slots_used >= SLOT_COUNT) begin
                    o.status = ST_FULL;
                end else begin
                    k = m_slots_used[IDX_W-1:0];
                    m_gen[k] = GEN_FIRST;
                    m_occupied[k] = 1'b1;
                    m_retired[k] = 1'b0;
                    m_slots_used++;
                    m_live++;
                    o.out_index = k;
                    o.out_generation = GEN_FIRST;
                end
            end
            ACT_UPDATE: begin
                if (!hit) begin
                    o.status = ST_STALE;
                end else begin
                    o.out_index = r.handle_index;
                    if (!r.descriptor_ok) o.status = ST_BAD_DESC;
                end
            end
            ACT_REMOVE: begin
                if (!hit) begin
                    o.status = ST_STALE;
                end else begin
                    m_occupied[r.handle_index] = 1'b0;
                    if (m_live != 0) m_live--;
                    release_slot(r.handle_index);
                    o.out_index = r.handle_index;
                end
            end
            ACT_LOOKUP: begin
                if (hit) o.out_index = r.handle_index;
                else o.status = ST_STALE;
            end
            ACT_STALE: begin
                if (hit) o.out_index = r.handle_index;
                o.is_stale = r.handle_present && !hit;
            end
            ACT_CLEAR: begin
                m_free_depth = '0;
                m_live = '0;
                for (int i = 0; i < int'(m_slots_used); i++) begin
                    m_occupied[i] = 1'b0;
                    if (!m_retired[i]) release_slot(IDX_W'(i));
                end
            end
            default: ;
        endcase
        o.live_count = m_live;
        return o;
    endfunction

    function automatic t_req pack_req(logic [ACTION_W-1:0] act, logic present,
                                      logic [OWNER_W-1:0] own, logic [HIDX_W-1:0] idx,
                                      logic [HGEN_W-1:0] gen, logic dok);
        t_req r;
        r.action = act;
        r.handle_present = present;
        r.handle_owner = own;
        r.handle_index = idx;
        r.handle_generation = gen;
        r.descriptor_ok = dok;
        return r;
    endfunction

    function automatic t_req noise_req(logic [ACTION_W-1:0] act);
        return pack_req(act, 1'($urandom_range(0, 1)), OWNER_W'($urandom),
                        HIDX_W'($urandom), HGEN_W'($urandom), 1'($urandom_range(0, 1)));
    endfunction

    function automatic t_req add_req(logic dok);
        t_req r;
        r = noise_req(ACT_ADD);
        r.descriptor_ok = dok;
        return r;
    endfunction

    // well-formed handle of a slot as the table holds it now
    function automatic t_req handle_req(logic [ACTION_W-1:0] act, logic [IDX_W-1:0] idx,
                                        logic dok);
        return pack_req(act, 1'b1, m_owner, idx, m_gen[idx], dok);
    endfunction

    function automatic logic [ACTION_W-1:0] handle_action();
        case ($urandom_range(0, 3))
            0: return ACT_UPDATE;
            1: return ACT_REMOVE;
            2: return ACT_LOOKUP;
            default: return ACT_STALE;
        endcase
    endfunction

    function automatic bit pick_live(output logic [IDX_W-1:0] idx);
        int start;
        int j;
        idx = '0;
        if (m_live == 0) return 1'b0;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++) begin
            j = (start + k) % SLOT_COUNT;
            if (j < int'(m_slots_used) && m_occupied[j] && !m_retired[j]) begin
                idx = IDX_W'(j);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_req random_item();
        int               p;
        logic [IDX_W-1:0] idx;
        t_req             r;
        p = $urandom_range(0, 199);
        if (p < 60) begin
            r = add_req($urandom_range(0, 19) != 0);
        end else if (p < 100) begin
            if (pick_live(idx)) r = handle_req(ACT_REMOVE, idx, 1'($urandom_range(0, 1)));
            else r = add_req(1'b1);
        end else if (p < 150) begin
            if (pick_live(idx)) r = handle_req(handle_action(), idx, $urandom_range(0, 7) != 0);
            else r = add_req(1'b1);
        end else if (p < 180) begin
            // near miss: a real handle with one part spoiled, or moved to another used slot
            if (pick_live(idx)) r = handle_req(handle_action(), idx, 1'($urandom_range(0, 1)));
            else r = noise_req(handle_action());
            case ($urandom_range(0, 4))
                0: r.handle_generation ^= HGEN_W'(1) << $urandom_range(0, HGEN_W - 1);
                1: r.handle_owner ^= OWNER_W'(1) << $urandom_range(0, OWNER_W - 1);
                2: r.handle_present = 1'b0;
                3: begin
                    if (m_slots_used < SLOT_COUNT)
                        r.handle_index = HIDX_W'($urandom_range(m_slots_used, SLOT_COUNT - 1));
                end
                default: begin
                    if (m_slots_used != 0) begin
                        idx = IDX_W'($urandom_range(0, m_slots_used - 1));
                        r.handle_index = idx;
                        r.handle_generation = m_gen[idx];
                    end
                end
            endcase
        end else if (p < 193) begin
            r = noise_req(ACTION_W'($urandom_range(0, 7)));
        end else if (p < 199) begin
            r = noise_req($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7);
        end else begin
            r = noise_req(ACT_CLEAR);
        end
        return r;
    endfunction

    // offer one request; the prediction is made when the transaction completes
    task automatic send_req(input t_req r);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        req_if.valid             <= 1'b1;
        req_if.action            <= r.action;
        req_if.handle_present    <= r.handle_present;
        req_if.handle_owner      <= r.handle_owner;
        req_if.handle_index      <= r.handle_index;
        req_if.handle_generation <= r.handle_generation;
        req_if.descriptor_ok     <= r.descriptor_ok;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        last_reply = apply_action(r);
        awaited_replies = {awaited_replies, last_reply};
    endtask

    task automatic drain_replies();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_replies.size() != 0);
    endtask

    task automatic write_owner(input logic [OWNER_W-1:0] v);
        drain_replies();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OWNER_ADDR;
        pwdata  <= PDATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        m_owner = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[OWNER_W-1:0] !== v) begin
            $error("owner_id readback: expected %0d, got %0d", v, prdata[OWNER_W-1:0]);
            err_count++;
        end
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reply();
        t_rsp want;
        if (awaited_replies.size() == 0) begin
            $error("reply with no request outstanding: status %0d index %0d",
                   rsp_if.status, rsp_if.out_index);
            err_count++;
            return;
        end
        want = awaited_replies.pop_front();
        if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            err_count++;
        end
        if (rsp_if.out_index !== want.out_index) begin
            $error("out_index: expected %0d, got %0d", want.out_index, rsp_if.out_index);
            err_count++;
        end
        if (rsp_if.out_generation !== want.out_generation) begin
            $error("out_generation: expected %0d, got %0d",
                   want.out_generation, rsp_if.out_generation);
            err_count++;
        end
        if (rsp_if.is_stale !== want.is_stale) begin
            $error("is_stale: expected %0d, got %0d", want.is_stale, rsp_if.is_stale);
            err_count++;
        end
        if (rsp_if.live_count !== want.live_count) begin
            $error("live_count: expected %0d, got %0d", want.live_count, rsp_if.live_count);
            err_count++;
        end
    endtask

    initial begin : reply_sink
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_reply();
            if (rsp_hold_start) begin
                rsp_hold_start = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (no_idle) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL generational_handle_table");
        $finish;
    end

    // two slots advanced through many generations by back-to-back clears
    task automatic test_generation_walk();
        logic [IDX_W-1:0]    ia;
        logic [IDX_W-1:0]    ib;
        logic [GEN_BITS-1:0] ga;
        no_idle = 1'b1;
        send_req(add_req(1'b1));
        ia = last_reply.out_index;
        send_req(add_req(1'b1));
        ib = last_reply.out_index;
        send_req(handle_req(ACT_REMOVE, ib, 1'b1));
        repeat (CLEAR_ROUNDS) send_req(noise_req(ACT_CLEAR));
        send_req(add_req(1'b1));
        ia = last_reply.out_index;
        ga = last_reply.out_generation;
        send_req(handle_req(ACT_LOOKUP, ia, 1'b1));
        send_req(handle_req(ACT_REMOVE, ia, 1'b1));
        send_req(pack_req(ACT_LOOKUP, 1'b1, m_owner, ia, ga, 1'b1));
        send_req(pack_req(ACT_STALE, 1'b1, m_owner, ib, GEN_MAX, 1'b1));
        send_req(add_req(1'b1));
        send_req(noise_req(ACT_CLEAR));
        no_idle = 1'b0;
    endtask

    task automatic test_directed();
        logic [IDX_W-1:0]    hi;
        logic [GEN_BITS-1:0] hg;
        write_owner('1);
        send_req(pack_req(ACT_ADD, 1'b0, '0, '0, '0, 1'b0));
        send_req(pack_req(ACT_ADD, 1'b1, '1, '1, '1, 1'b1));
        hi = last_reply.out_index;
        hg = last_reply.out_generation;
        send_req(pack_req(ACT_UPDATE, 1'b1, m_owner, hi, hg, 1'b1));
        send_req(pack_req(ACT_UPDATE, 1'b1, m_owner, hi, hg, 1'b0));
        send_req(pack_req(ACT_UPDATE, 1'b1, OWNER_RESET, hi, hg, 1'b1));
        send_req(pack_req(ACT_LOOKUP, 1'b1, m_owner, hi, ~hg, 1'b1));
        send_req(pack_req(ACT_LOOKUP, 1'b0, m_owner, hi, hg, 1'b1));
        send_req(pack_req(ACT_LOOKUP, 1'b1, m_owner, '1, '0, 1'b0));
        send_req(pack_req(ACT_STALE, 1'b1, m_owner, hi, hg, 1'b0));
        send_req(pack_req(ACT_STALE, 1'b0, '0, '0, '0, 1'b0));
        send_req(pack_req(ACT_STALE, 1'b1, m_owner, hi, hg + 1'b1, 1'b1));
        send_req(pack_req(ACT_SPARE7, 1'b1, '1, '1, '1, 1'b1));
        send_req(pack_req(ACT_SPARE6, 1'b0, '0, '0, '0, 1'b0));
        send_req(pack_req(ACT_REMOVE, 1'b1, m_owner, hi, hg, 1'b1));
        send_req(pack_req(ACT_REMOVE, 1'b1, m_owner, hi, hg, 1'b1));
        // freed slot comes back with the next generation
        send_req(pack_req(ACT_ADD, 1'b0, '0, '0, '0, 1'b1));
        hi = last_reply.out_index;
        hg = last_reply.out_generation;
        send_req(pack_req(ACT_LOOKUP, 1'b1, m_owner, hi, hg, 1'b0));
        send_req(pack_req(ACT_LOOKUP, 1'b1, m_owner, hi, '0, 1'b1));
        send_req(pack_req(ACT_CLEAR, 1'b1, '1, '1, '1, 1'b1));
        send_req(pack_req(ACT_LOOKUP, 1'b1, m_owner, hi, hg, 1'b1));
        send_req(pack_req(ACT_STALE, 1'b1, m_owner, hi, hg + 1'b1, 1'b1));
        send_req(pack_req(ACT_ADD, 1'b1, '0, '0, '0, 1'b1));
    endtask

    // fill every slot while the result side first holds off, then hit the full table
    task automatic test_capacity();
        logic [IDX_W-1:0] idx;
        write_owner(OWNER_W'($urandom_range(2, 65534)));
        rsp_hold_start = 1'b1;
        while (m_free_depth != 0 || m_slots_used < SLOT_COUNT) send_req(add_req(1'b1));
        send_req(add_req(1'b1));
        send_req(add_req(1'b0));
        repeat (3) begin
            if (pick_live(idx)) send_req(handle_req(ACT_REMOVE, idx, 1'b1));
        end
        repeat (4) send_req(add_req(1'b1));
        if (m_occupied[SLOT_COUNT-1]) send_req(handle_req(ACT_LOOKUP, '1, 1'b1));
        send_req(noise_req(ACT_CLEAR));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_owner(OWNER_RESET);
                2: write_owner('1);
                default: write_owner(OWNER_W'($urandom_range(1, 65535)));
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // sender pauses until the table has answered everything
                if (n == RANDOM_PER_PHASE / 2) drain_replies();
                send_req(random_item());
            end
        end
    endtask

    initial begin
        err_count      = 0;
        no_idle        = 1'b0;
        rsp_hold_start = 1'b0;
        m_free_depth   = '0;
        m_slots_used   = '0;
        m_live         = '0;
        m_owner        = OWNER_RESET;
        i_rst_n                  <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        req_if.valid             <= 1'b0;
        req_if.action            <= ACT_ADD;
        req_if.handle_present    <= 1'b0;
        req_if.handle_owner      <= '0;
        req_if.handle_index      <= '0;
        req_if.handle_generation <= '0;
        req_if.descriptor_ok     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_generation_walk();
        test_directed();
        test_capacity();
        test_random_traffic();

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_replies.size() != 0) begin
            $error("%0d replies never arrived", awaited_replies.size());
            err_count++;
        end
        if (err_count == 0)
            $display("PASS generational_handle_table");
        else
            $display("FAIL generational_handle_table");
        $finish;
    end

endmodule
